// ===== rtl/pls_pkg.sv =====
// shared types, constants and constant functions of the phong/lambert shader
// no dependencies; every other rtl file refers to this package by scoped names
`default_nettype none

package pls_pkg;

  localparam int FRACTION_BITS = 14;
  localparam int COMP_W        = 16;
  localparam int TETA_SHIFT    = 2 * FRACTION_BITS - 16;
  localparam int TETA_W        = 20;
  localparam int D_W           = 22;
  localparam int NUM_W         = 40;
  localparam int NORM_W        = 44;
  localparam int LOG_W         = NORM_W;
  localparam int LOG_P_W       = 6;
  localparam int LOG_FR_W      = 16;
  localparam int LOG_Q_W       = LOG_P_W + LOG_FR_W;
  localparam int LOG_STEPS     = 16;
  localparam int LOG_LAT       = LOG_STEPS + 2;
  localparam int EXP_STEPS     = 16;
  localparam int VALUE_W       = 57;
  localparam int COEF_W        = 30;
  localparam int SHIN_W        = 12;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  localparam logic [18:0] INV_PI_Q20  = 19'd333772;
  localparam logic [17:0] INV_2PI_Q20 = 18'd166886;
  localparam logic [VALUE_W-1:0] SAT_CAP = VALUE_W'(1) << 56;
  localparam logic [SHIN_W-1:0] SHIN_RESET = 12'd16;

  typedef enum logic [1:0] {
    MODE_LAMBERT    = 2'd0,
    MODE_HALF_PHONG = 2'd1,
    MODE_NORM_PHONG = 2'd2,
    MODE_BASE_PHONG = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE           = 3'd0,
    REG_DIFFUSE_RED    = 3'd1,
    REG_DIFFUSE_GREEN  = 3'd2,
    REG_DIFFUSE_BLUE   = 3'd3,
    REG_SPECULAR_RED   = 3'd4,
    REG_SPECULAR_GREEN = 3'd5,
    REG_SPECULAR_BLUE  = 3'd6,
    REG_SHININESS      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] view_x;
    logic signed [COMP_W-1:0] view_y;
    logic signed [COMP_W-1:0] view_z;
    logic signed [COMP_W-1:0] light_x;
    logic signed [COMP_W-1:0] light_y;
    logic signed [COMP_W-1:0] light_z;
    logic signed [COMP_W-1:0] normal_x;
    logic signed [COMP_W-1:0] normal_y;
    logic signed [COMP_W-1:0] normal_z;
  } hit_t;

  typedef struct packed {
    logic [15:0] shade_red;
    logic [15:0] shade_green;
    logic [15:0] shade_blue;
  } shade_t;

  typedef struct packed {
    mode_t             mode;
    logic [2:0][15:0]  kd;
    logic [2:0][15:0]  ks;
    logic [SHIN_W-1:0] shininess;
  } cfg_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [NORM_W-1:0]       norm2;
    logic [TETA_W-1:0]       teta;
  } geom_t;

  typedef struct packed {
    logic [TETA_W-1:0]  teta;
    logic [VALUE_W-1:0] value;
  } spec_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-k) in q1.30, each link truncated as in the square root chain
  function automatic logic [30:0] chain_const(input int k);
    logic [63:0] c;
    c = isqrt64(64'd1 << 61);
    for (int j = 2; j <= EXP_STEPS; j++) begin
      if (j <= k) c = isqrt64(c << 30);
    end
    return c[30:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pls_ifs.sv =====
// valid/ready channel interfaces for shading requests and shaded colors
// payload types come from pls_pkg
`default_nettype none

interface pls_hit_if;
  logic          valid;
  logic          ready;
  pls_pkg::hit_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface pls_shade_if;
  logic            valid;
  logic            ready;
  pls_pkg::shade_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pls_regs.sv =====
// apb configuration registers: model mode, reflectances and shininess
// uses pls_pkg
`default_nettype none

module pls_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pls_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pls_pkg::DATA_W-1:0] pwdata,
  output logic      [pls_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output pls_pkg::cfg_t                   cfg
);

  pls_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = pls_pkg::reg_idx_t'(paddr[pls_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= pls_pkg::MODE_LAMBERT;
      cfg.kd        <= '0;
      cfg.ks        <= '0;
      cfg.shininess <= pls_pkg::SHIN_RESET;
    end else if (wr) begin
      unique case (idx)
        pls_pkg::REG_MODE:           cfg.mode      <= pls_pkg::mode_t'(pwdata[1:0]);
        pls_pkg::REG_DIFFUSE_RED:    cfg.kd[0]     <= pwdata[15:0];
        pls_pkg::REG_DIFFUSE_GREEN:  cfg.kd[1]     <= pwdata[15:0];
        pls_pkg::REG_DIFFUSE_BLUE:   cfg.kd[2]     <= pwdata[15:0];
        pls_pkg::REG_SPECULAR_RED:   cfg.ks[0]     <= pwdata[15:0];
        pls_pkg::REG_SPECULAR_GREEN: cfg.ks[1]     <= pwdata[15:0];
        pls_pkg::REG_SPECULAR_BLUE:  cfg.ks[2]     <= pwdata[15:0];
        pls_pkg::REG_SHININESS:      cfg.shininess <= pwdata[pls_pkg::SHIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      pls_pkg::REG_MODE:           prdata = pls_pkg::DATA_W'(cfg.mode);
      pls_pkg::REG_DIFFUSE_RED:    prdata = pls_pkg::DATA_W'(cfg.kd[0]);
      pls_pkg::REG_DIFFUSE_GREEN:  prdata = pls_pkg::DATA_W'(cfg.kd[1]);
      pls_pkg::REG_DIFFUSE_BLUE:   prdata = pls_pkg::DATA_W'(cfg.kd[2]);
      pls_pkg::REG_SPECULAR_RED:   prdata = pls_pkg::DATA_W'(cfg.ks[0]);
      pls_pkg::REG_SPECULAR_GREEN: prdata = pls_pkg::DATA_W'(cfg.ks[1]);
      pls_pkg::REG_SPECULAR_BLUE:  prdata = pls_pkg::DATA_W'(cfg.ks[2]);
      pls_pkg::REG_SHININESS:      prdata = pls_pkg::DATA_W'(cfg.shininess);
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pls_geom.sv =====
// vector pipeline: cos theta, half or mirrored direction, its dot and squared length
// six register stages; uses pls_pkg
`default_nettype none

module pls_geom (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  pls_pkg::hit_t       in_data,
  input  pls_pkg::mode_t      mode,
  output logic                out_valid,
  output pls_pkg::geom_t      out_data
);

  localparam int STAGES = 6;
  localparam int W = pls_pkg::COMP_W;
  localparam int D = pls_pkg::D_W;

  logic [STAGES-1:0] vld;

  logic signed [W-1:0] cv [3];
  logic signed [W-1:0] cl [3];
  logic signed [W-1:0] cn [3];

  logic signed [W-1:0]  s1_v [3];
  logic signed [W-1:0]  s1_l [3];
  logic signed [W-1:0]  s1_n [3];
  logic signed [31:0]   s1_pl [3];
  logic signed [31:0]   s1_pv [3];
  logic signed [17:0]   s1_dh [3];

  logic signed [W-1:0]  s2_v [3];
  logic signed [W-1:0]  s2_l [3];
  logic signed [W-1:0]  s2_n [3];
  logic signed [17:0]   s2_dh [3];
  logic signed [33:0]   s2_dnl;
  logic signed [33:0]   s2_dnv;

  logic signed [W-1:0]  s3_v [3];
  logic signed [W-1:0]  s3_l [3];
  logic signed [W-1:0]  s3_n [3];
  logic signed [17:0]   s3_dh [3];
  logic signed [50:0]   s3_q [3];
  logic [pls_pkg::TETA_W-1:0] s3_teta;

  logic signed [D-1:0]  s4_d [3];
  logic signed [W-1:0]  s4_e [3];
  logic [pls_pkg::TETA_W-1:0] s4_teta;

  logic signed [37:0]   s5_pde [3];
  logic signed [43:0]   s5_pdd [3];
  logic [pls_pkg::TETA_W-1:0] s5_teta;

  always_comb begin
    cv[0] = in_data.view_x;
    cv[1] = in_data.view_y;
    cv[2] = in_data.view_z;
    cl[0] = in_data.light_x;
    cl[1] = in_data.light_y;
    cl[2] = in_data.light_z;
    cn[0] = in_data.normal_x;
    cn[1] = in_data.normal_y;
    cn[2] = in_data.normal_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_v[i]  <= cv[i];
        s1_l[i]  <= cl[i];
        s1_n[i]  <= cn[i];
        s1_pl[i] <= cn[i] * cl[i];
        s1_pv[i] <= cn[i] * cv[i];
        s1_dh[i] <= (18'(cl[i]) <<< 1) - 18'(cv[i]);

        s2_v[i]  <= s1_v[i];
        s2_l[i]  <= s1_l[i];
        s2_n[i]  <= s1_n[i];
        s2_dh[i] <= s1_dh[i];

        s3_v[i]  <= s2_v[i];
        s3_l[i]  <= s2_l[i];
        s3_n[i]  <= s2_n[i];
        s3_dh[i] <= s2_dh[i];
        s3_q[i]  <= 51'(s2_dnv) * 51'(s2_n[i]) * 51'sd2;

        if (mode == pls_pkg::MODE_HALF_PHONG) begin
          s4_d[i] <= D'(s3_dh[i]);
          s4_e[i] <= s3_n[i];
        end else begin
          s4_d[i] <= D'(s3_v[i]) - D'(s3_q[i] >>> (2 * pls_pkg::FRACTION_BITS));
          s4_e[i] <= s3_l[i];
        end

        s5_pde[i] <= 38'(s4_d[i]) * 38'(s4_e[i]);
        s5_pdd[i] <= 44'(s4_d[i]) * 44'(s4_d[i]);
      end
      s2_dnl <= 34'(s1_pl[0]) + 34'(s1_pl[1]) + 34'(s1_pl[2]);
      s2_dnv <= 34'(s1_pv[0]) + 34'(s1_pv[1]) + 34'(s1_pv[2]);
      s3_teta <= (s2_dnl > 34'sd0) ?
                 s2_dnl[pls_pkg::TETA_SHIFT +: pls_pkg::TETA_W] : '0;
      s4_teta <= s3_teta;
      s5_teta <= s4_teta;
      out_data.num   <= pls_pkg::NUM_W'(s5_pde[0]) + pls_pkg::NUM_W'(s5_pde[1])
                        + pls_pkg::NUM_W'(s5_pde[2]);
      out_data.norm2 <= pls_pkg::NORM_W'(s5_pdd[0] + s5_pdd[1] + s5_pdd[2]);
      out_data.teta  <= s5_teta;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pls_log2.sv =====
// pipelined log2 in q.16: leading one, normalize, then one squaring per stage
// uses pls_pkg
`default_nettype none

module pls_log2 (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [pls_pkg::LOG_W-1:0]   x,
  output logic      [pls_pkg::LOG_Q_W-1:0] y
);

  localparam int N = pls_pkg::LOG_STEPS;
  localparam int P = pls_pkg::LOG_P_W;

  logic [P-1:0]              lead;
  logic [pls_pkg::LOG_W-1:0] a_x;
  logic [P-1:0]              a_p;
  logic [30:0]               norm;

  logic [30:0]                  m_s [N+1];
  logic [pls_pkg::LOG_FR_W-1:0] fr_s [N+1];
  logic [P-1:0]                 p_s [N+1];
  logic [61:0]                  sq [N];

  always_comb begin
    lead = '0;
    for (int i = 0; i < pls_pkg::LOG_W; i++) begin
      if (x[i]) lead = P'(i);
    end
  end

  always_comb begin
    if (a_p >= P'(30)) begin
      norm = 31'(a_x >> (a_p - P'(30)));
    end else begin
      norm = 31'(a_x << (P'(30) - a_p));
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      sq[k] = 62'(m_s[k]) * 62'(m_s[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x     <= x;
      a_p     <= lead;
      m_s[0]  <= norm;
      fr_s[0] <= '0;
      p_s[0]  <= a_p;
      for (int k = 0; k < N; k++) begin
        p_s[k+1] <= p_s[k];
        if (sq[k][61]) begin
          m_s[k+1]  <= sq[k][61:31];
          fr_s[k+1] <= {fr_s[k][pls_pkg::LOG_FR_W-2:0], 1'b1};
        end else begin
          m_s[k+1]  <= sq[k][60:30];
          fr_s[k+1] <= {fr_s[k][pls_pkg::LOG_FR_W-2:0], 1'b0};
        end
      end
    end
  end

  assign y = {p_s[N], fr_s[N]};

endmodule

`default_nettype wire

// ===== rtl/pls_spec.sv =====
// specular power pipeline: cos alpha^n as exp2(n * log2(cos alpha))
// two pls_log2 units, exponent scaling, sqrt(2) chain exp2, final shift; uses pls_pkg
`default_nettype none

module pls_spec (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  pls_pkg::geom_t                   in_data,
  input  wire logic [pls_pkg::SHIN_W-1:0]  shininess,
  output logic                             out_valid,
  output pls_pkg::spec_t                   out_data
);

  localparam int LL  = pls_pkg::LOG_LAT;
  localparam int NE  = pls_pkg::EXP_STEPS;
  localparam int LAT = LL + NE + 4;

  typedef struct packed {
    logic [pls_pkg::TETA_W-1:0] teta;
    logic                       pos;
  } side_t;

  logic [LAT-1:0] vld;

  logic [pls_pkg::LOG_Q_W-1:0] log_num;
  logic [pls_pkg::LOG_Q_W-1:0] log_norm;

  side_t sd [LL];
  side_t p1_side;
  side_t p2_side;

  logic signed [23:0] p1_lga;
  logic signed [36:0] prod_p;
  logic signed [32:0] p2_lp;

  side_t              x_side [NE+1];
  logic signed [17:0] x_ip [NE+1];
  logic [15:0]        x_f [NE+1];
  logic [30:0]        x_r [NE+1];
  logic [61:0]        rm [NE];

  logic [63:0]        shl;
  logic [17:0]        neg;
  logic [pls_pkg::VALUE_W-1:0] value;

  pls_log2 u_log_num (
    .clk (clk),
    .en  (en),
    .x   (pls_pkg::LOG_W'(in_data.num)),
    .y   (log_num)
  );

  pls_log2 u_log_norm (
    .clk (clk),
    .en  (en),
    .x   (in_data.norm2),
    .y   (log_norm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[LAT-1];

  assign prod_p = 37'(p1_lga) * 37'($signed({1'b0, shininess}));

  always_comb begin
    for (int j = 0; j < NE; j++) begin
      rm[j] = 62'(x_r[j]) * 62'(pls_pkg::chain_const(j + 1));
    end
  end

  // final scaling by the integer part of the exponent
  always_comb begin
    shl   = 64'(x_r[NE]) << x_ip[NE][4:0];
    neg   = -x_ip[NE];
    value = '0;
    if (shininess == '0) begin
      value = pls_pkg::VALUE_W'(64'd1 << 32);
    end else if (!x_side[NE].pos) begin
      value = '0;
    end else if (!x_ip[NE][17]) begin
      if (x_ip[NE] > 18'sd30) begin
        value = pls_pkg::SAT_CAP;
      end else if (shl > 64'(pls_pkg::SAT_CAP)) begin
        value = pls_pkg::SAT_CAP;
      end else begin
        value = pls_pkg::VALUE_W'(shl);
      end
    end else if (neg > 18'd31) begin
      value = '0;
    end else begin
      value = pls_pkg::VALUE_W'(x_r[NE] >> neg[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0].teta <= in_data.teta;
      sd[0].pos  <= !in_data.num[pls_pkg::NUM_W-1] && (in_data.num != '0) &&
                    (in_data.norm2 != '0);
      for (int i = 1; i < LL; i++) begin
        sd[i] <= sd[i-1];
      end

      p1_side <= sd[LL-1];
      p1_lga  <= 24'(log_num) - 24'(log_norm >> 1) - 24'(pls_pkg::FRACTION_BITS << 16);

      p2_side <= p1_side;
      p2_lp   <= 33'(prod_p >>> 4);

      x_side[0] <= p2_side;
      x_ip[0]   <= 18'(p2_lp >>> 16) + 18'sd2;
      x_f[0]    <= p2_lp[15:0];
      x_r[0]    <= 31'd1 << 30;

      for (int j = 0; j < NE; j++) begin
        x_side[j+1] <= x_side[j];
        x_ip[j+1]   <= x_ip[j];
        x_f[j+1]    <= x_f[j];
        if (x_f[j][NE-1-j]) begin
          x_r[j+1] <= rm[j][60:30];
        end else begin
          x_r[j+1] <= x_r[j];
        end
      end

      out_data.teta  <= x_side[NE].teta;
      out_data.value <= value;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pls_color.sv =====
// color stage: diffuse and specular terms per channel, sum, saturate to q8.8
// two-entry output queue and the pipeline advance enable; uses pls_pkg, pls_ifs
`default_nettype none

module pls_color (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  pls_pkg::spec_t       in_data,
  input  pls_pkg::cfg_t        cfg,
  output logic                 en,
  pls_shade_if.source          shade
);

  localparam int VW = pls_pkg::VALUE_W;

  logic [2:0] vld;
  logic [pls_pkg::COEF_W-1:0] coef;

  logic [72:0] c1_prod [3];
  logic [54:0] c2_scaled [3];
  logic [87:0] c3_full [3];

  logic [2:0][35:0]    c1_dif;
  logic [2:0][VW-1:0]  c1_sa;
  logic [2:0][35:0]    c2_dif;
  logic [2:0][VW-1:0]  c2_sa;
  logic [2:0][58:0]    c2_pph;
  logic [2:0][57:0]    c2_ppl;
  logic [2:0][35:0]    c3_dif;
  logic [2:0][VW-1:0]  c3_spec;

  logic [57:0] tot [3];
  logic [33:0] scaled [3];
  logic [15:0] chan [3];
  pls_pkg::shade_t nw;

  logic [1:0]      cnt;
  pls_pkg::shade_t q0;
  pls_pkg::shade_t q1;
  logic            push;
  logic            pop;

  always_ff @(posedge clk) begin
    coef <= pls_pkg::COEF_W'((32'(cfg.shininess) + 32'd32) * 32'(pls_pkg::INV_2PI_Q20));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c1_prod[i]   = 73'(in_data.value) * 73'(cfg.ks[i]);
      c2_scaled[i] = 55'(c1_dif[i]) * 55'(pls_pkg::INV_PI_Q20);
      c3_full[i]   = (88'(c2_pph[i]) << 28) + 88'(c2_ppl[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c1_dif[i] <= 36'(cfg.kd[i]) * 36'(in_data.teta);
        c1_sa[i]  <= (c1_prod[i][72:64] != '0) ? pls_pkg::SAT_CAP : VW'(c1_prod[i][63:16]);

        c2_sa[i]  <= c1_sa[i];
        c2_pph[i] <= 59'(c1_sa[i][VW-1:28]) * 59'(coef);
        c2_ppl[i] <= 58'(c1_sa[i][27:0]) * 58'(coef);
        case (cfg.mode) inside
          pls_pkg::MODE_HALF_PHONG, pls_pkg::MODE_NORM_PHONG:
            c2_dif[i] <= 36'(c2_scaled[i][54:20]);
          default:
            c2_dif[i] <= c1_dif[i];
        endcase

        c3_dif[i] <= c2_dif[i];
        case (cfg.mode) inside
          pls_pkg::MODE_HALF_PHONG, pls_pkg::MODE_NORM_PHONG:
            c3_spec[i] <= (c3_full[i][87:64] != '0) ? pls_pkg::SAT_CAP :
                          VW'(c3_full[i][63:24]);
          pls_pkg::MODE_BASE_PHONG:
            c3_spec[i] <= c2_sa[i];
          default:
            c3_spec[i] <= '0;
        endcase
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = 58'(c3_dif[i]) + 58'(c3_spec[i]);
      if (tot[i] > 58'(pls_pkg::SAT_CAP)) tot[i] = 58'(pls_pkg::SAT_CAP);
      scaled[i] = 34'(tot[i] >> 24);
      chan[i]   = (scaled[i] > 34'hFFFF) ? 16'hFFFF : scaled[i][15:0];
    end
    nw.shade_red   = chan[0];
    nw.shade_green = chan[1];
    nw.shade_blue  = chan[2];
  end

  // output queue lets the pipeline keep moving while one result waits
  assign en   = !(vld[2] && (cnt == 2'd2) && !shade.ready);
  assign push = en && vld[2];
  assign pop  = shade.valid && shade.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) q0 <= nw;
        else q1 <= nw;
      end
      2'b01: q0 <= q1;
      2'b11: begin
        if (cnt == 2'd1) begin
          q0 <= nw;
        end else begin
          q0 <= q1;
          q1 <= nw;
        end
      end
      default: ;
    endcase
  end

  assign shade.valid = (cnt != 2'd0);
  assign shade.data  = q0;

endmodule

`default_nettype wire

// ===== rtl/phong_lambert_shader.sv =====
// top level of the phong/lambert shading unit
// uses pls_pkg, pls_ifs, pls_regs, pls_geom, pls_spec, pls_color
`default_nettype none

// Shades one ray hit per cycle unless held: view, light and normal vectors in
// q1.14 go in on the hit channel, saturated q8.8 rgb comes out on the shade
// channel. The pipeline has 6 vector stages, 38 in the log2/exp2 power path and
// 3 color stages, and the output queue registers each result. The power path is
// the longest: one squaring per log2 stage and one chain multiply per exp2
// stage. A two-entry queue at the output lets new hits be taken while a result
// waits; the pipeline holds only when that queue is full, the receiver is not
// ready and the last stage is occupied. Registers must be written over apb only
// while no hit is in flight; the block does not enforce it.
module phong_lambert_shader (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pls_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pls_pkg::DATA_W-1:0] pwdata,
  output logic      [pls_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  pls_hit_if.sink                         hit,
  pls_shade_if.source                     shade
);

  pls_pkg::cfg_t  cfg;
  pls_pkg::geom_t geom;
  pls_pkg::spec_t spec;
  logic           en;
  logic           geom_valid;
  logic           spec_valid;

  assign hit.ready = en;

  pls_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pls_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (hit.valid),
    .in_data   (hit.data),
    .mode      (cfg.mode),
    .out_valid (geom_valid),
    .out_data  (geom)
  );

  pls_spec u_spec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (geom_valid),
    .in_data   (geom),
    .shininess (cfg.shininess),
    .out_valid (spec_valid),
    .out_data  (spec)
  );

  pls_color u_color (
    .clk      (clk),
    .rst      (rst),
    .in_valid (spec_valid),
    .in_data  (spec),
    .cfg      (cfg),
    .en       (en),
    .shade    (shade)
  );

endmodule

`default_nettype wire
